// ===== src/part_pkg.sv =====
// Package: shared constants, command codes and types for the active ratio tracker
`timescale 1ns / 1ps
package part_pkg;
    localparam int HIST_DEPTH_DEF = 16;
    localparam logic [31:0] PERIOD_RST = 32'd4000000;
    localparam logic [4:0] HLEN_RST = 5'd10;
    localparam int RATIO_SHIFT = 10;
    localparam logic [10:0] RATIO_FULL = 11'd1024;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ENQ = 2'd1;
    localparam logic [1:0] CMD_DEQ = 2'd2;
    localparam logic [1:0] CMD_UPD = 2'd3;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_HLEN = 1'b1;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

// ===== src/part_div.sv =====
// Shared radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
`timescale 1ns / 1ps
module part_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  part_pkg::t_div_req i_req,
    output part_pkg::t_div_rsp o_rsp
);
    logic [63:0] r_q, n_q;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dv;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh, w_sub;

    always_comb begin
        w_sh  = {r_rem, r_q[63]};
        w_sub = w_sh - {1'b0, r_dv};
        n_q   = {r_q[62:0], ~w_sub[32]};
        n_rem = w_sub[32] ? w_sh[31:0] : w_sub[31:0];
        n_cnt = r_cnt + 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dv   <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;
endmodule

// ===== src/periodic_active_ratio_tracker.sv =====
// Top level: command sequencer, history ring and result register of the active ratio tracker
`timescale 1ns / 1ps
// Sequence: a start, or a request before start, goes straight to the output state; other
// requests add one divider pass, a second when running, a third when running and periods
// closed, plus the history push, one entry per step (1..17 entries) when periods closed.
// Flow: one request at a time; busy is high from accept to the result strobe, so a new
// request is taken only after the previous result. Results never stall.
// Reset: synchronous active low; state and the registered history valid bits clear at once.
module periodic_active_ratio_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_now_ns,
    input  logic [15:0] i_tasks_running,
    input  logic [3:0]  i_read_index,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [10:0] o_recent_ratio,
    output logic [3:0]  o_history_index,
    output logic [10:0] o_history_value,
    output logic        o_is_running
);
    localparam int HISTORY_DEPTH = part_pkg::HIST_DEPTH_DEF;
    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_RAT  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;
    localparam logic [2:0] S_RAT2 = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [31:0] r_period;
    logic [4:0]  r_hlen;
    logic        r_run;
    logic [63:0] r_origin, r_last;
    logic [31:0] r_sum;
    logic [10:0] r_ratio;
    logic [3:0]  r_pos;
    logic [10:0] r_hist [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hval;
    logic [2:0]  r_st;
    logic [1:0]  r_cmd;
    logic [63:0] r_now, r_count;
    logic [31:0] r_rem;
    logic [15:0] r_tasks;
    logic [3:0]  r_ridx;
    logic [CW-1:0] r_npush;
    logic        r_first;
    logic        r_wait;
    logic        r_acct;

    part_pkg::t_div_req r_req;
    part_pkg::t_div_rsp w_rsp;

    part_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    logic [31:0] w_per;
    logic [4:0]  w_hl;
    logic [63:0] w_end, w_upto, w_delta, w_sum64;
    logic [31:0] w_sumsat;
    logic [63:0] w_extra;
    logic [CW-1:0] w_npush;
    logic [4:0]  w_posn;
    logic [10:0] w_rsat;

    function automatic logic [4:0] mod_len(input logic [4:0] a, input logic [4:0] m);
        logic [9:0] r;
        r = {5'd0, a};
        for (int s = 4; s >= 0; s--) begin
            if (r >= ({5'd0, m} << s)) r = r - ({5'd0, m} << s);
        end
        return r[4:0];
    endfunction

    always_comb begin
        w_per = (r_period == 32'd0) ? 32'd1 : r_period;
        w_hl  = (r_hlen == 5'd0) ? 5'd1 : r_hlen;
        if (32'(w_hl) > 32'(HISTORY_DEPTH)) w_hl = 5'(HISTORY_DEPTH);
        w_end   = r_origin + {32'd0, w_per};
        w_upto  = (r_now < w_end) ? r_now : w_end;
        w_delta = w_upto - r_last;
        w_sum64 = {32'd0, r_sum} + w_delta;
        w_sumsat = (w_sum64 < w_delta || w_sum64[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                  : w_sum64[31:0];
        w_extra = r_count - 64'd1;
        w_npush = (w_extra > 64'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH + 1)
                                                  : CW'(w_extra[IW:0] + 1);
        w_posn = mod_len(5'(r_pos) + 5'd1, w_hl);
        w_rsat = (w_rsp.quot > 64'(part_pkg::RATIO_FULL)) ? part_pkg::RATIO_FULL
                                                          : w_rsp.quot[10:0];
    end

    assign busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= part_pkg::PERIOD_RST;
            r_hlen   <= part_pkg::HLEN_RST;
            r_run    <= 1'b0;
            r_origin <= '0;
            r_last   <= '0;
            r_sum    <= '0;
            r_ratio  <= '0;
            r_pos    <= '0;
            r_hval   <= '0;
            r_st     <= S_IDLE;
            r_wait   <= 1'b0;
            o_valid  <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            r_req.start <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == part_pkg::CFG_PERIOD) r_period <= i_cfg_data;
                else r_hlen <= i_cfg_data[4:0];
            end
            unique case (r_st)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_command; r_now <= i_now_ns;
                        r_tasks <= i_tasks_running; r_ridx <= i_read_index;
                        r_acct <= (i_command != part_pkg::CMD_START) && (r_origin != 64'd0);
                        if (i_command == part_pkg::CMD_START) begin
                            if (r_origin == 64'd0) begin
                                r_origin <= i_now_ns;
                                r_last   <= i_now_ns;
                            end
                            r_st <= S_OUT;
                        end else if (r_origin == 64'd0) begin
                            r_st <= S_OUT;
                        end else begin
                            r_req.start    <= 1'b1;
                            r_req.dividend <= i_now_ns - r_origin;
                            r_req.divisor  <= w_per;
                            r_st <= S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    if (w_rsp.done) begin
                        r_count <= w_rsp.quot;
                        r_rem   <= w_rsp.rem;
                        if (r_run) begin
                            r_sum <= w_sumsat;
                            r_req.start    <= 1'b1;
                            r_req.dividend <= {22'd0, w_sumsat, 10'd0};
                            r_req.divisor  <= w_per;
                            r_st <= S_RAT;
                        end else if (w_rsp.quot != 64'd0) begin
                            r_first <= 1'b1;
                            r_st <= S_PUSH;
                        end else begin
                            r_last <= r_now;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_RAT: begin
                    if (w_rsp.done) begin
                        r_ratio <= w_rsat;
                        if (r_count != 64'd0) begin
                            r_first <= 1'b1;
                            r_st <= S_PUSH;
                        end else begin
                            r_last <= r_now;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_PUSH: begin
                    if (r_first) begin
                        r_npush <= w_npush;
                        r_first <= 1'b0;
                    end else if (r_npush != '0) begin
                        r_pos <= w_posn[3:0];
                        r_hist[w_posn[IW-1:0]] <= (r_npush == w_npush) ? r_ratio
                                                : (r_run ? part_pkg::RATIO_FULL : 11'd0);
                        r_hval[w_posn[IW-1:0]] <= 1'b1;
                        r_npush <= r_npush - CW'(1);
                    end else begin
                        r_origin <= r_now - {32'd0, r_rem};
                        r_last   <= r_now;
                        if (r_run) begin
                            r_sum <= r_rem;
                            r_req.start    <= 1'b1;
                            r_req.dividend <= {22'd0, r_rem, 10'd0};
                            r_req.divisor  <= w_per;
                            r_st <= S_RAT2;
                        end else begin
                            r_ratio <= '0;
                            r_sum   <= '0;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_RAT2: begin
                    if (w_rsp.done) begin
                        r_ratio <= w_rsat;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_acct && r_cmd == part_pkg::CMD_ENQ && r_tasks == 16'd0)
                        r_run <= 1'b1;
                    else if (r_acct && r_cmd == part_pkg::CMD_DEQ && r_tasks == 16'd1)
                        r_run <= 1'b0;
                    r_wait <= 1'b1;
                    if (r_wait) begin
                        r_wait  <= 1'b0;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT && r_wait) begin
            o_recent_ratio  <= r_ratio;
            o_history_index <= r_pos;
            o_is_running    <= r_run;
            o_history_value <= (32'(r_ridx) < 32'(HISTORY_DEPTH)
                                && r_hval[r_ridx[IW-1:0]]) ? r_hist[r_ridx[IW-1:0]] : 11'd0;
        end
    end

    a_ratio_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_recent_ratio <= part_pkg::RATIO_FULL) else $error("ratio above full");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < 32'(HISTORY_DEPTH)) else $error("ring position out of range");
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the periodic active ratio tracker: random and directed requests, scoreboard check
`timescale 1ns / 1ps
module testbench;
    localparam int DEPTH = part_pkg::HIST_DEPTH_DEF;

    typedef struct {
        logic [1:0]  command;
        logic [63:0] now_ns;
        logic [15:0] tasks;
        logic [3:0]  read_index;
        bit          hold;
    } t_request;

    typedef struct {
        logic [10:0] ratio;
        logic [3:0]  ring_pos;
        logic [10:0] hist_val;
        logic        running;
    } t_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [63:0] i_now_ns;
    logic [15:0] i_tasks_running;
    logic [3:0]  i_read_index;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [10:0] o_recent_ratio;
    logic [3:0]  o_history_index;
    logic [10:0] o_history_value;
    logic        o_is_running;

    periodic_active_ratio_tracker dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // tracker model state
    logic [31:0] m_period;
    logic [4:0]  m_hlen;
    logic        m_running;
    logic [63:0] m_origin;
    logic [63:0] m_last;
    logic [31:0] m_busy_sum;
    logic [10:0] m_ratio;
    logic [3:0]  m_pos;
    logic [10:0] m_hist [DEPTH];

    t_request req_q[$];
    t_status  status_q[$];
    t_request cur_req;
    int       gap_left;
    bit       no_gaps;
    int       errors;
    logic [63:0] t_now;

    function automatic logic [63:0] eff_period();
        return (m_period == 0) ? 64'd1 : {32'd0, m_period};
    endfunction

    function automatic logic [10:0] ratio_for(logic [31:0] sum);
        logic [63:0] r;
        r = ({32'd0, sum} << part_pkg::RATIO_SHIFT) / eff_period();
        return (r > 64'd1024) ? part_pkg::RATIO_FULL : r[10:0];
    endfunction

    function automatic void push_entry(logic [10:0] v);
        int n;
        n = (m_hlen == 0) ? 1 : ((m_hlen > DEPTH) ? DEPTH : int'(m_hlen));
        m_pos = 4'((int'(m_pos) + 1) % n);
        m_hist[m_pos] = v;
    endfunction

    function automatic void close_periods(bit full, logic [63:0] extra);
        if (extra > 64'(DEPTH)) extra = 64'(DEPTH);
        push_entry(m_ratio);
        for (int k = 0; k < extra; k++) push_entry(full ? part_pkg::RATIO_FULL : 11'd0);
    endfunction

    function automatic void account_time(logic [63:0] now);
        logic [63:0] per, elapsed, cnt, per_stop, upto, delta;
        logic [64:0] sum;
        per = eff_period();
        elapsed = now - m_origin;
        cnt = elapsed / per;
        if (m_running) begin
            per_stop = m_origin + per;
            upto = (now < per_stop) ? now : per_stop;
            delta = upto - m_last;
            sum = {33'd0, m_busy_sum} + {1'b0, delta};
            m_busy_sum = (sum > 65'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
            m_ratio = ratio_for(m_busy_sum);
            if (cnt != 0) begin
                close_periods(1'b1, cnt - 1);
                m_busy_sum = 32'(elapsed % per);
                m_ratio = ratio_for(m_busy_sum);
            end
        end else if (cnt != 0) begin
            close_periods(1'b0, cnt - 1);
            m_ratio = '0;
            m_busy_sum = '0;
        end
        m_origin = m_origin + per * cnt;
        m_last = now;
    endfunction

    function automatic t_status track_event(t_request r);
        t_status s;
        if (r.command == part_pkg::CMD_START) begin
            if (m_origin == 0) begin
                m_origin = r.now_ns;
                m_last = r.now_ns;
            end
        end else if (m_origin != 0) begin
            account_time(r.now_ns);
            if (r.command == part_pkg::CMD_ENQ && r.tasks == 0) m_running = 1'b1;
            else if (r.command == part_pkg::CMD_DEQ && r.tasks == 1) m_running = 1'b0;
        end
        s.ratio = m_ratio;
        s.ring_pos = m_pos;
        s.hist_val = m_hist[r.read_index];
        s.running = m_running;
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        bit accepted, launch;
        accepted = 0;
        launch = 0;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            accepted = start && !busy;
            if (accepted) status_q.push_back(track_event(cur_req));
            if (accepted || !start) begin
                if (gap_left > 0) gap_left--;
                else if (req_q.size() > 0 && !(req_q[0].hold && status_q.size() > 0))
                    launch = 1;
            end
            if (launch) begin
                cur_req = req_q.pop_front();
                i_command <= cur_req.command;
                i_now_ns <= cur_req.now_ns;
                i_tasks_running <= cur_req.tasks;
                i_read_index <= cur_req.read_index;
                start <= 1'b1;
                gap_left = pick_gap();
            end else if (accepted) begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_status e;
        if (i_rst_n && o_valid) begin
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result ratio=%0d idx=%0d val=%0d run=%0d", $time,
                         o_recent_ratio, o_history_index, o_history_value, o_is_running);
            end else begin
                e = status_q.pop_front();
                if (o_recent_ratio !== e.ratio || o_history_index !== e.ring_pos ||
                    o_history_value !== e.hist_val || o_is_running !== e.running) begin
                    errors++;
                    $display("%0t: mismatch expected ratio=%0d idx=%0d val=%0d run=%0d",
                             $time, e.ratio, e.ring_pos, e.hist_val, e.running);
                    $display("%0t:          actual   ratio=%0d idx=%0d val=%0d run=%0d",
                             $time, o_recent_ratio, o_history_index, o_history_value,
                             o_is_running);
                end
            end
        end
    end

    task automatic add_req(logic [1:0] c, logic [63:0] t, logic [15:0] n, logic [3:0] ri,
                           bit h = 0);
        t_request r;
        r.command = c;
        r.now_ns = t;
        r.tasks = n;
        r.read_index = ri;
        r.hold = h;
        req_q.push_back(r);
    endtask

    task automatic wait_idle();
        while (req_q.size() > 0 || status_q.size() > 0 || start || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] per, logic [4:0] hl);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= part_pkg::CFG_PERIOD;
        i_cfg_data <= per;
        m_period = per;
        @(posedge i_clk);
        i_cfg_index <= part_pkg::CFG_HLEN;
        i_cfg_data <= {27'd0, hl};
        m_hlen = hl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(int count, logic [63:0] per);
        logic [1:0]  c;
        logic [15:0] n;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) t_now = t_now + rand64() % (per + 1);
            else if (r < 88) t_now = t_now + per * $urandom_range(1, 22) + rand64() % per;
            else if (r < 94) t_now = t_now - rand64() % (per * 3 + 1);
            else t_now = rand64();
            r = $urandom_range(0, 99);
            c = (r < 6) ? part_pkg::CMD_START : (r < 40) ? part_pkg::CMD_ENQ
              : (r < 75) ? part_pkg::CMD_DEQ : part_pkg::CMD_UPD;
            r = $urandom_range(0, 99);
            n = (r < 40) ? 16'd0 : (r < 80) ? 16'd1 : (r < 90) ? 16'd2 : 16'($urandom());
            add_req(c, t_now, n, 4'($urandom()), $urandom_range(0, 99) == 0);
            if (i % 50 == 0) no_gaps = $urandom_range(0, 3) == 0;
        end
    endtask

    initial begin
        errors = 0;
        no_gaps = 0;
        start = 1'b0;
        i_command = part_pkg::CMD_START;
        i_now_ns = '0;
        i_tasks_running = '0;
        i_read_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = part_pkg::CFG_PERIOD;
        i_cfg_data = '0;
        m_period = part_pkg::PERIOD_RST;
        m_hlen = part_pkg::HLEN_RST;
        m_running = 0;
        m_origin = '0;
        m_last = '0;
        m_busy_sum = '0;
        m_ratio = '0;
        m_pos = '0;
        foreach (m_hist[k]) m_hist[k] = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored before start, start at zero, transitions, wrap, extremes
        add_req(part_pkg::CMD_START, 64'd0, 16'd0, 4'd0);
        add_req(part_pkg::CMD_ENQ, 64'd100, 16'd0, 4'd15);
        add_req(part_pkg::CMD_START, 64'd1000, 16'd0, 4'd0);
        add_req(part_pkg::CMD_START, 64'd5000, 16'd0, 4'd1);
        add_req(part_pkg::CMD_ENQ, 64'd2000, 16'd0, 4'd1);
        add_req(part_pkg::CMD_UPD, 64'd3000000, 16'd3, 4'd0);
        add_req(part_pkg::CMD_DEQ, 64'd4500000, 16'd1, 4'd1, 1);
        add_req(part_pkg::CMD_ENQ, 64'd5000000, 16'd0, 4'd2);
        add_req(part_pkg::CMD_UPD, 64'd90000000, 16'd0, 4'd9);
        add_req(part_pkg::CMD_DEQ, 64'd90001000, 16'hFFFF, 4'd15);
        add_req(part_pkg::CMD_DEQ, 64'd90002000, 16'd1, 4'd3);
        add_req(part_pkg::CMD_UPD, 64'd10, 16'd0, 4'd4);
        add_req(part_pkg::CMD_ENQ, 64'd20, 16'd0, 4'd5);
        add_req(part_pkg::CMD_UPD, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 4'd6);
        add_req(part_pkg::CMD_ENQ, 64'hAAAA_5555_AAAA_5555, 16'h5555, 4'd10);
        add_req(part_pkg::CMD_UPD, 64'h5555_AAAA_5555_AAAA, 16'hAAAA, 4'd7);
        add_req(part_pkg::CMD_DEQ, 64'h5555_AAAA_5555_B000, 16'd1, 4'd8, 1);
        add_req(part_pkg::CMD_UPD, 64'h5555_AAAA_6000_0000, 16'd0, 4'd11);
        t_now = 64'h5555_AAAA_6000_0000;

        set_config(32'd1000, 5'd16);
        random_phase(250, 64'd1000);
        set_config(32'd1, 5'd1);
        random_phase(150, 64'd1);
        set_config(32'hFFFF_FFFF, 5'd16);
        random_phase(150, 64'hFFFF_FFFF);
        set_config(32'd37, 5'd5);
        random_phase(250, 64'd37);
        set_config(part_pkg::PERIOD_RST, part_pkg::HLEN_RST);
        random_phase(250, 64'd4000000);

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench failed");
        $finish;
    end
endmodule
